@@ rtl/smce_pkg.sv @@
// Shared types, command codes and font tables of the scrolling marquee column engine.
package smce_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_ACK    = 1'b1;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;

    localparam int GLYPH_COLS = 5;
    localparam int OP_COLS    = 6;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] column_bits;
        logic       last_column;
        logic       dropped;
    } t_out_item;

    typedef struct packed {
        logic [1:0]              command;
        logic [2:0]              len;
        logic [OP_COLS-1:0][7:0] cols;
    } t_op;

    typedef struct packed {
        logic                       found;
        logic [GLYPH_COLS-1:0][7:0] cols;
    } t_glyph;

    // column 0 sits in the low byte
    localparam logic [39:0] DIGIT_FONT [10] = '{
        40'h001E21211E, 40'h0000003F02, 40'h0026293122, 40'h001B252511,
        40'h003F08080F, 40'h0019252527, 40'h001925251E, 40'h0003050931,
        40'h001A25251A, 40'h001E292926
    };

    localparam logic [39:0] UPPER_FONT [26] = '{
        40'h003E09093E, 40'h001A25253F, 40'h000021211E, 40'h001E21213F,
        40'h002525253F, 40'h000505053F, 40'h003D25211E, 40'h003F04043F,
        40'h000000003F, 40'h00001F2030, 40'h0021120C3F, 40'h000020203F,
        40'h3F020C023F, 40'h003F08043F, 40'h001E21211E, 40'h000609093F,
        40'h2E1129211E, 40'h002619093F, 40'h0019252522, 40'h0001013F01,
        40'h001F20201F, 40'h0F1020100F, 40'h1F201C201F, 40'h00330C0C33,
        40'h0304380403, 40'h0023252931
    };

    localparam logic [39:0] LOWER_FONT [26] = '{
        40'h2018242418, 40'h001824243F, 40'h0000242418, 40'h003F242418,
        40'h00002C3438, 40'h0000093E08, 40'h0078A4A498, 40'h003804043F,
        40'h000000003D, 40'h00007D8080, 40'h000024183F, 40'h000000003F,
        40'h380438043C, 40'h003804043C, 40'h0018242418, 40'h00182424FC,
        40'h00FC242418, 40'h0000040438, 40'h0014342C28, 40'h0000243F04,
        40'h001C20201C, 40'h0C1020100C, 40'h1C201C201C, 40'h0024181824,
        40'h00007CA09C, 40'h00242C3424
    };

    function automatic t_glyph glyph_lookup(input logic [7:0] code);
        t_glyph     g;
        logic [7:0] rel;
        g   = '0;
        rel = '0;
        if (code >= CH_ZERO && code <= CH_NINE) begin
            rel     = code - CH_ZERO;
            g.found = 1'b1;
            g.cols  = DIGIT_FONT[rel[3:0]];
        end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
            rel     = code - CH_UPPER_A;
            g.found = 1'b1;
            g.cols  = UPPER_FONT[rel[4:0]];
        end else if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
            rel     = code - CH_LOWER_A;
            g.found = 1'b1;
            g.cols  = LOWER_FONT[rel[4:0]];
        end
        return g;
    endfunction

endpackage

@@ rtl/smce_fifo.sv @@
// Small synchronous FIFO used for the command queue and the result queue.
module smce_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [LW-1:0]    r_level, n_level;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_level == LW'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_level = r_level;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_level = r_level + LW'(1);
        end else if (do_pop && !do_push) begin
            n_level = r_level - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/smce_front.sv @@
// Front end: accepts commands, expands characters through the font and queues operations.
module smce_front (
    input  logic              i_push,
    input  logic              i_full,
    input  smce_pkg::t_in_item i_item,
    output logic              o_op_push,
    output smce_pkg::t_op     o_op
);

    import smce_pkg::*;

    t_glyph     glyph;
    logic [2:0] lead;
    logic       run;

    always_comb begin
        glyph = glyph_lookup(i_item.char_code);
        lead  = '0;
        run   = 1'b1;
        for (int i = 0; i < GLYPH_COLS; i++) begin
            if (run && glyph.cols[i] != 8'd0) begin
                lead = lead + 3'd1;
            end else begin
                run = 1'b0;
            end
        end
    end

    always_comb begin
        o_op         = '0;
        o_op.command = i_item.command;
        if (i_item.command == CMD_LOAD) begin
            if (i_item.char_code == CH_SPACE) begin
                o_op.len = 3'd2;
            end else if (glyph.found) begin
                o_op.len = lead + 3'd1;
                for (int i = 0; i < GLYPH_COLS; i++) begin
                    if (3'(i) < lead) begin
                        o_op.cols[i] = glyph.cols[i];
                    end
                end
            end
        end
    end

    // drop the unused command code here
    assign o_op_push = i_push && !i_full &&
                       (i_item.command == CMD_CLEAR || i_item.command == CMD_LOAD ||
                        i_item.command == CMD_TICK);

endmodule

@@ rtl/smce_back.sv @@
// Back end: column store, message length, scroll offset and result sequencing.
module smce_back #(
    parameter int WINDOW        = 35,
    parameter int STORE_COLUMNS = 2048,
    parameter int RES_DEPTH     = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_op_empty,
    input  smce_pkg::t_op                  i_op,
    output logic                           o_op_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0] i_res_level,
    output logic                           o_res_push,
    output smce_pkg::t_out_item            o_res
);

    import smce_pkg::*;

    localparam int AW = $clog2(STORE_COLUMNS);
    localparam int CW = $clog2(STORE_COLUMNS + 1);
    localparam int JW = $clog2(WINDOW + 1);
    localparam int LW = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;

    logic [7:0] r_store [STORE_COLUMNS];

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_offset, n_offset;
    logic [CW-1:0]           r_addr, n_addr;
    logic [JW-1:0]           r_j, n_j;
    logic [2:0]              r_idx, n_idx;
    logic [2:0]              r_len, n_len;
    logic [OP_COLS-1:0][7:0] r_cols, n_cols;
    logic                    r_res_valid, n_res_valid;
    logic                    r_res_kind, n_res_kind;
    logic                    r_res_last, n_res_last;
    logic                    r_res_drop, n_res_drop;
    logic                    r_res_show, n_res_show;
    logic [7:0]              r_mem_q;

    logic          room;
    logic [LW:0]   occ;
    logic [CW:0]   load_end;
    logic [CW-1:0] addr_inc;
    logic [CW-1:0] off_inc;
    logic          load_last;
    logic          tick_last;
    logic          wr_en;
    logic          rd_en;

    assign occ       = {1'b0, i_res_level} + {{LW{1'b0}}, r_res_valid};
    assign room      = occ < (LW+1)'(RES_DEPTH);
    assign load_end  = {1'b0, r_count} + (CW+1)'(i_op.len);
    assign addr_inc  = r_addr + CW'(1);
    assign off_inc   = CW'(r_offset) + CW'(1);
    assign load_last = (r_idx == r_len - 3'd1);
    assign tick_last = (r_j == JW'(WINDOW - 1)) || (addr_inc == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_offset    = r_offset;
        n_addr      = r_addr;
        n_j         = r_j;
        n_idx       = r_idx;
        n_len       = r_len;
        n_cols      = r_cols;
        n_res_valid = 1'b0;
        n_res_kind  = KIND_ACK;
        n_res_last  = 1'b1;
        n_res_drop  = 1'b0;
        n_res_show  = 1'b0;
        o_op_pop    = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_op_empty && room) begin
                    o_op_pop = 1'b1;
                    unique case (i_op.command)
                        CMD_CLEAR: begin
                            n_count     = CW'(WINDOW);
                            n_offset    = '0;
                            n_res_valid = 1'b1;
                        end
                        CMD_LOAD: begin
                            if (i_op.len == 3'd0) begin
                                n_res_valid = 1'b1;
                            end else if (load_end > (CW+1)'(STORE_COLUMNS)) begin
                                n_res_valid = 1'b1;
                                n_res_drop  = 1'b1;
                            end else begin
                                n_state = S_LOAD;
                                n_addr  = r_count;
                                n_idx   = '0;
                                n_len   = i_op.len;
                                n_cols  = i_op.cols;
                            end
                        end
                        CMD_TICK: begin
                            n_state = S_TICK;
                            n_addr  = CW'(r_offset);
                            n_j     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (!load_last || room) begin
                    wr_en  = 1'b1;
                    n_addr = addr_inc;
                    n_idx  = r_idx + 3'd1;
                    if (load_last) begin
                        n_count     = addr_inc;
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_TICK: begin
                if (room) begin
                    rd_en       = 1'b1;
                    n_res_valid = 1'b1;
                    n_res_kind  = KIND_COLUMN;
                    n_res_last  = tick_last;
                    n_res_show  = (r_addr >= CW'(WINDOW));
                    n_addr      = addr_inc;
                    n_j         = r_j + JW'(1);
                    if (tick_last) begin
                        n_offset = (off_inc >= r_count) ? '0 : off_inc[AW-1:0];
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(WINDOW);
            r_offset    <= '0;
            r_addr      <= '0;
            r_j         <= '0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_offset    <= n_offset;
            r_addr      <= n_addr;
            r_j         <= n_j;
            r_idx       <= n_idx;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_cols     <= n_cols;
        r_res_kind <= n_res_kind;
        r_res_last <= n_res_last;
        r_res_drop <= n_res_drop;
        r_res_show <= n_res_show;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_addr[AW-1:0]] <= r_cols[r_idx];
        end
        if (rd_en) begin
            r_mem_q <= r_store[r_addr[AW-1:0]];
        end
    end

    assign o_res_push        = r_res_valid;
    assign o_res.kind        = r_res_kind;
    assign o_res.column_bits = r_res_show ? r_mem_q : 8'd0;
    assign o_res.last_column = r_res_last;
    assign o_res.dropped     = r_res_drop;

endmodule

@@ rtl/scrolling_marquee_column_engine_unit.sv @@
// Top level of the scrolling marquee column engine: command queue, front end, back end, result queue.
//
//   channel   handshake           payload
//   command   push / full         i_item  (command, char_code)
//   result    empty / pop         o_item  (kind, column_bits, last_column, dropped)
//
// In the back end a clear resets the message length and offset, a load writes 2 to 6 columns when stored,
// and a tick reads one column from the column memory per emitted column, up to WINDOW columns.
// Load writes and tick reads share the single address of the column memory.
// Reset empties both queues and sets WINDOW blank columns and a zero offset;
// the column store itself is not cleared. A full result queue stalls the back end,
// and a full command queue raises full.
module scrolling_marquee_column_engine_unit #(
    parameter int WINDOW        = 35,
    parameter int STORE_COLUMNS = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  smce_pkg::t_in_item   i_item,
    output logic                 empty,
    input  logic                 pop,
    output smce_pkg::t_out_item  o_item
);

    import smce_pkg::*;

    localparam int OP_DEPTH  = 2;
    localparam int RES_DEPTH = 4;
    localparam int OPW       = $bits(t_op);
    localparam int RESW      = $bits(t_out_item);

    logic                           op_push;
    t_op                            op_in;
    logic [OPW-1:0]                 op_data;
    logic                           op_pop;
    logic                           op_full;
    logic                           op_empty;
    logic [$clog2(OP_DEPTH+1)-1:0]  op_level;
    logic                           res_push;
    t_out_item                      res_in;
    logic [RESW-1:0]                res_data;
    logic                           res_full;
    logic [$clog2(RES_DEPTH+1)-1:0] res_level;

    assign full = op_full;

    smce_front u_front (
        .i_push    (push),
        .i_full    (op_full),
        .i_item    (i_item),
        .o_op_push (op_push),
        .o_op      (op_in)
    );

    smce_fifo #(
        .WIDTH (OPW),
        .DEPTH (OP_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .i_pop   (op_pop),
        .o_data  (op_data),
        .o_full  (op_full),
        .o_empty (op_empty),
        .o_level (op_level)
    );

    smce_back #(
        .WINDOW        (WINDOW),
        .STORE_COLUMNS (STORE_COLUMNS),
        .RES_DEPTH     (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_empty  (op_empty),
        .i_op        (t_op'(op_data)),
        .o_op_pop    (op_pop),
        .i_res_level (res_level),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    smce_fifo #(
        .WIDTH (RESW),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_full  (res_full),
        .o_empty (empty),
        .o_level (res_level)
    );

    assign o_item = t_out_item'(res_data);

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_op_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_push |-> !op_full)
        else $error("command pushed into a full command queue");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.kind == KIND_ACK) |-> (o_item.last_column && o_item.column_bits == 8'd0))
        else $error("acknowledge with column data or without last flag");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_level <= ($clog2(OP_DEPTH+1))'(OP_DEPTH))
        else $error("command queue level out of range");

endmodule
